// File: sv/bmhpq_pkg.sv
// bmhpq_pkg: shared types and codes for the binary max-heap priority queue
// used by bmhpq_ram users and binary_max_heap_priority_queue; no dependencies
package bmhpq_pkg;

  localparam int unsigned PrioW = 16;
  localparam int unsigned DataW = 32;
  localparam int unsigned EntryW = PrioW + DataW;
  localparam int unsigned CountOutW = 7;

  localparam logic OpInsert = 1'b0;
  localparam logic OpDelete = 1'b1;

  typedef struct packed {
    logic [PrioW-1:0] prio;
    logic [DataW-1:0] data;
  } entry_t;

endpackage

// File: sv/bmhpq_ram.sv
// bmhpq_ram: generic single-write, dual-read RAM with registered read data
// no package dependencies
module bmhpq_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  output logic [Width-1:0]         rdata_a_o,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// File: sv/binary_max_heap_priority_queue.sv
// binary max-heap priority queue: one insert or delete-max per item, sifted in a RAM
// busy: insert sifts the new entry up; delete-max moves the last entry to the root and sifts it down
// then a one-cycle result strobe with busy low; a refused item reports in the next cycle
// one item at a time; each level is read, compare, write
// reset clears the count and the sequencer; heap RAM contents are not cleared
// results are strobed on done_o for one cycle and cannot be stalled
module binary_max_heap_priority_queue #(
  parameter int unsigned STORE_DEPTH = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        operation_i,
  input  logic [15:0] priority_req_i,
  input  logic [31:0] payload_i,
  output logic        done_o,
  output logic [15:0] top_priority_o,
  output logic [31:0] top_payload_o,
  output logic        top_valid_o,
  output logic [6:0]  entry_count_o,
  output logic        rejected_o
);

  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam int unsigned IW = AW + 1;

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StUpRd   = 3'd1;
  localparam logic [2:0] StUpCmp  = 3'd2;
  localparam logic [2:0] StDnLast = 3'd3;
  localparam logic [2:0] StDnRd   = 3'd4;
  localparam logic [2:0] StDnCmp  = 3'd5;

  localparam logic [AW-1:0] Cap = AW'(STORE_DEPTH - 1);
  localparam logic [AW-1:0] Root = AW'(1);

  logic [2:0]            state_q, state_d;
  logic [AW-1:0]         idx_q, idx_d;
  logic [AW-1:0]         count_q, count_d;
  bmhpq_pkg::entry_t     mov_q, mov_d;
  bmhpq_pkg::entry_t     top_q, top_d;
  logic                  rej_q, rej_d;
  logic                  done_q, done_d;

  logic                  we;
  logic [AW-1:0]         waddr;
  bmhpq_pkg::entry_t     wdata;
  logic [AW-1:0]         raddr_a, raddr_b;
  logic [bmhpq_pkg::EntryW-1:0] rdata_a_raw, rdata_b_raw;
  bmhpq_pkg::entry_t     rdata_a, rdata_b;

  logic                  accept;
  logic                  is_full, is_empty;
  logic [AW-1:0]         parent_idx;
  logic [IW-1:0]         left_idx, right_idx, count_ext;
  logic                  has_left, has_right, pick_right;
  bmhpq_pkg::entry_t     pick;
  logic [AW-1:0]         pick_idx;
  logic [AW+bmhpq_pkg::CountOutW-1:0] count_wide;

  assign rdata_a = bmhpq_pkg::entry_t'(rdata_a_raw);
  assign rdata_b = bmhpq_pkg::entry_t'(rdata_b_raw);

  assign accept   = start && !busy;
  assign is_full  = (count_q == Cap);
  assign is_empty = (count_q == '0);

  assign parent_idx = idx_q >> 1;
  assign left_idx   = {idx_q, 1'b0};
  assign right_idx  = {idx_q, 1'b1};
  assign count_ext  = {1'b0, count_q};
  assign has_left   = (left_idx <= count_ext);
  assign has_right  = (right_idx <= count_ext);

  // right child wins only when strictly greater
  assign pick_right = has_right && (rdata_b.prio > rdata_a.prio);
  assign pick       = pick_right ? rdata_b : rdata_a;
  assign pick_idx   = pick_right ? right_idx[AW-1:0] : left_idx[AW-1:0];

  always_comb begin
    raddr_a = count_q;
    raddr_b = count_q;
    unique case (state_q)
      StUpRd: begin
        raddr_a = parent_idx;
      end
      StDnRd: begin
        raddr_a = left_idx[AW-1:0];
        raddr_b = has_right ? right_idx[AW-1:0] : left_idx[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    count_d = count_q;
    mov_d   = mov_q;
    rej_d   = rej_q;
    done_d  = 1'b0;
    we      = 1'b0;
    waddr   = idx_q;
    wdata   = mov_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          rej_d = 1'b0;
          if (operation_i == bmhpq_pkg::OpInsert) begin
            if (is_full) begin
              rej_d  = 1'b1;
              done_d = 1'b1;
            end else begin
              count_d    = count_q + AW'(1);
              idx_d      = count_q + AW'(1);
              mov_d.prio = priority_req_i;
              mov_d.data = payload_i;
              state_d    = StUpRd;
            end
          end else begin
            if (is_empty) begin
              rej_d  = 1'b1;
              done_d = 1'b1;
            end else begin
              // last entry is being read at the old count
              count_d = count_q - AW'(1);
              state_d = StDnLast;
            end
          end
        end
      end
      StUpRd: begin
        if (idx_q == Root) begin
          we      = 1'b1;
          state_d = StIdle;
          done_d  = 1'b1;
        end else begin
          state_d = StUpCmp;
        end
      end
      StUpCmp: begin
        we = 1'b1;
        if (mov_q.prio > rdata_a.prio) begin
          wdata   = rdata_a;
          idx_d   = parent_idx;
          state_d = StUpRd;
        end else begin
          state_d = StIdle;
          done_d  = 1'b1;
        end
      end
      StDnLast: begin
        if (is_empty) begin
          state_d = StIdle;
          done_d  = 1'b1;
        end else begin
          mov_d   = rdata_a;
          idx_d   = Root;
          state_d = StDnRd;
        end
      end
      StDnRd: begin
        if (has_left) begin
          state_d = StDnCmp;
        end else begin
          we      = 1'b1;
          state_d = StIdle;
          done_d  = 1'b1;
        end
      end
      StDnCmp: begin
        we = 1'b1;
        if (pick.prio > mov_q.prio) begin
          wdata   = pick;
          idx_d   = pick_idx;
          state_d = StDnRd;
        end else begin
          state_d = StIdle;
          done_d  = 1'b1;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // shadow copy of the root so results need no extra read
  always_comb begin
    top_d = top_q;
    if (we && (waddr == Root)) begin
      top_d = wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      rej_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      rej_q   <= rej_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    mov_q <= mov_d;
    top_q <= top_d;
  end

  bmhpq_ram #(
    .Width (bmhpq_pkg::EntryW),
    .Depth (STORE_DEPTH)
  ) u_heap_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .rdata_a_o (rdata_a_raw),
    .raddr_b_i (raddr_b),
    .rdata_b_o (rdata_b_raw)
  );

  assign busy = (state_q != StIdle);

  assign count_wide     = {{bmhpq_pkg::CountOutW{1'b0}}, count_q};
  assign done_o         = done_q;
  assign top_valid_o    = !is_empty;
  assign top_priority_o = is_empty ? '0 : top_q.prio;
  assign top_payload_o  = is_empty ? '0 : top_q.data;
  assign entry_count_o  = count_wide[bmhpq_pkg::CountOutW-1:0];
  assign rejected_o     = rej_q;

  a_done_when_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == StIdle))
    else $error("result strobe while sequencer busy");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Cap)
    else $error("entry count beyond capacity");

  a_reject_fast : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && ((operation_i == bmhpq_pkg::OpInsert && is_full) ||
                (operation_i == bmhpq_pkg::OpDelete && is_empty)))
    |=> (done_q && rej_q && $stable(count_q)))
    else $error("refused item did not report at once with count unchanged");

  a_no_idle_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (state_q != StIdle))
    else $error("heap write outside an operation");

endmodule
